[sv/cta_pkg.sv]
// cta_pkg: shared types and constants for the channel trimmed average smoother
// holds the per-channel entry layout and the controller/datapath command and status structs
// no dependencies
package cta_pkg;

    localparam int CH_W       = 5;
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 8;
    localparam int SUM_W      = 14;
    localparam int EXT_W      = 10;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = 24;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = 4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT  = 16'd1023;
    localparam logic [CNT_W-1:0]    WINDOW_LEN    = 4'd10;
    localparam logic [SAMPLE_W-1:0] INVALID_VALUE = 16'hffff;
    localparam logic signed [SAMPLE_W:0] JUMP_POS = 17'sd100;
    localparam logic signed [SAMPLE_W:0] JUMP_NEG = -17'sd100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smooth;
        logic [SUM_W-1:0]    win_sum;
        logic [EXT_W-1:0]    win_max;
        logic [EXT_W-1:0]    win_min;
        logic [CNT_W-1:0]    win_count;
    } entry_t;

    typedef struct packed {
        logic load;
        logic read;
        logic calc;
        logic mul;
        logic div_start;
        logic div_step;
        logic write;
        logic write_smooth;
        logic emit;
        logic emit_ok;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic averaging;
        logic sample_bad;
        logic win_full;
        logic jump;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

[sv/cta_datapath.sv]
// cta_datapath: per-channel state memory, window update, smoother and bit-serial divider
// depends on cta_pkg; driven by cta_ctrl through cta_pkg::cmd_t
module cta_datapath #(
    parameter int CHANNELS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cta_pkg::CH_W-1:0]        channel,
    input  logic [cta_pkg::SAMPLE_W-1:0]    sample,
    input  logic [cta_pkg::WEIGHT_W-1:0]    weight,
    input  logic                            counter_range,
    input  logic                            pre_average_enable,
    input  cta_pkg::cmd_t                   cmd,
    output cta_pkg::status_t                status,
    input  logic                            result_stall,
    output logic                            result_valid,
    output logic [cta_pkg::SAMPLE_W-1:0]    value,
    output logic                            valid_res
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // captured item
    logic [cta_pkg::CH_W-1:0]      ch_reg;
    logic [cta_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [cta_pkg::WEIGHT_W-1:0]  weight_reg;
    logic                          cr_reg;

    cta_pkg::entry_t               mem [CHANNELS];
    logic [CHANNELS-1:0]           written_reg;
    cta_pkg::entry_t               rd_entry_reg;
    logic                          rd_hit_reg;

    cta_pkg::entry_t               old_entry;
    cta_pkg::entry_t               calc_entry;
    cta_pkg::entry_t               win_reg;
    cta_pkg::entry_t               wr_entry;
    logic                          win_full_reg;
    logic [cta_pkg::SAMPLE_W-1:0]  seff_reg;

    logic [IDX_W-1:0]              idx;
    logic [cta_pkg::EXT_W-1:0]     s10;
    logic [cta_pkg::CNT_W-1:0]     cnt_inc;
    logic [cta_pkg::EXT_W-1:0]     max_new;
    logic [cta_pkg::EXT_W-1:0]     min_new;
    logic [cta_pkg::SUM_W-1:0]     sum_acc;
    logic [cta_pkg::EXT_W:0]       drop;
    logic [cta_pkg::SUM_W-1:0]     trimmed;
    logic                          full;
    logic                          averaging;

    logic signed [cta_pkg::SAMPLE_W:0] delta;
    logic signed [cta_pkg::SAMPLE_W:0] half;
    logic signed [cta_pkg::SAMPLE_W:0] jump_sum;
    logic                          jump;
    logic [cta_pkg::NUM_W-1:0]     product;
    logic [cta_pkg::NUM_W-1:0]     num;
    logic [cta_pkg::NUM_W-1:0]     num_reg;
    logic                          jump_reg;

    logic [cta_pkg::WEIGHT_W:0]    divisor;
    logic [cta_pkg::WEIGHT_W-1:0]  rem_reg;
    logic [cta_pkg::SAMPLE_W-1:0]  quot_reg;
    logic [cta_pkg::STEP_W-1:0]    step_reg;
    logic [cta_pkg::WEIGHT_W:0]    trial;
    logic                          ge;
    logic [cta_pkg::WEIGHT_W:0]    trial_sub;

    logic                          result_valid_reg;
    logic [cta_pkg::SAMPLE_W-1:0]  value_reg;
    logic                          valid_res_reg;

    assign idx       = IDX_W'(ch_reg);
    assign averaging = pre_average_enable && !cr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg     <= channel;
            sample_reg <= sample;
            weight_reg <= weight;
            cr_reg     <= counter_range;
        end
    end

    // per-channel state, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.write)
            mem[idx] <= wr_entry;
        if (cmd.read)
        begin
            rd_entry_reg <= mem[idx];
            rd_hit_reg   <= written_reg[idx];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            written_reg <= '0;
        else if (cmd.write)
            written_reg[idx] <= 1'b1;
    end

    assign old_entry = rd_hit_reg ? rd_entry_reg : '0;

    // window update
    always_comb
    begin
        s10     = sample_reg[cta_pkg::EXT_W-1:0];
        cnt_inc = old_entry.win_count + 1'b1;
        if (old_entry.win_count == '0)
        begin
            max_new = s10;
            min_new = s10;
            sum_acc = cta_pkg::SUM_W'(s10);
        end
        else
        begin
            max_new = (s10 > old_entry.win_max) ? s10 : old_entry.win_max;
            min_new = (s10 < old_entry.win_min) ? s10 : old_entry.win_min;
            sum_acc = old_entry.win_sum + cta_pkg::SUM_W'(s10);
        end
        full    = (cnt_inc >= cta_pkg::WINDOW_LEN);
        drop    = {1'b0, max_new} + {1'b0, min_new};
        trimmed = (sum_acc >= cta_pkg::SUM_W'(drop)) ? sum_acc - cta_pkg::SUM_W'(drop) : '0;

        calc_entry = old_entry;
        if (averaging)
        begin
            calc_entry.win_max   = max_new;
            calc_entry.win_min   = min_new;
            calc_entry.win_count = full ? '0 : cnt_inc;
            calc_entry.win_sum   = full ? trimmed : sum_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            win_reg      <= calc_entry;
            win_full_reg <= full;
            seff_reg     <= averaging ? cta_pkg::SAMPLE_W'(trimmed >> 3) : sample_reg;
        end
    end

    // jump test and weighted numerator
    always_comb
    begin
        delta    = $signed({1'b0, seff_reg}) - $signed({1'b0, win_reg.smooth});
        jump     = (delta >= cta_pkg::JUMP_POS) || (delta <= cta_pkg::JUMP_NEG);
        half     = delta >>> 1;
        jump_sum = $signed({1'b0, win_reg.smooth}) + half;
        product  = cta_pkg::NUM_W'(weight_reg) * cta_pkg::NUM_W'(win_reg.smooth);
    end

    assign num     = num_reg;
    assign divisor = {1'b0, weight_reg} + 1'b1;
    assign trial   = {rem_reg, quot_reg[cta_pkg::SAMPLE_W-1]};
    assign ge      = (trial >= divisor);
    assign trial_sub = trial - divisor;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            num_reg  <= product + cta_pkg::NUM_W'(seff_reg);
            jump_reg <= jump;
            if (jump)
                quot_reg <= jump_sum[cta_pkg::SAMPLE_W-1:0];
        end
        else if (cmd.div_start)
        begin
            // quotient fits 16 bits, so the high byte is already below the divisor
            rem_reg  <= num[cta_pkg::NUM_W-1:cta_pkg::SAMPLE_W];
            quot_reg <= num[cta_pkg::SAMPLE_W-1:0];
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? trial_sub[cta_pkg::WEIGHT_W-1:0] : trial[cta_pkg::WEIGHT_W-1:0];
            quot_reg <= {quot_reg[cta_pkg::SAMPLE_W-2:0], ge};
            step_reg <= step_reg + 1'b1;
        end
    end

    always_comb
    begin
        wr_entry = win_reg;
        if (cmd.write_smooth)
            wr_entry.smooth = quot_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            value_reg     <= cmd.emit_ok ? quot_reg : cta_pkg::INVALID_VALUE;
            valid_res_reg <= cmd.emit_ok;
        end
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign valid_res    = valid_res_reg;

    assign status.in_range   = (int'(ch_reg) < CHANNELS);
    assign status.averaging  = averaging;
    assign status.sample_bad = (sample_reg > cta_pkg::SAMPLE_LIMIT);
    assign status.win_full   = win_full_reg;
    assign status.jump       = jump_reg;
    assign status.div_last   = (step_reg == cta_pkg::STEP_W'(cta_pkg::DIV_STEPS - 1));
    assign status.out_free   = !result_valid_reg || !result_stall;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> status.in_range)
        else $error("state write for a channel out of range");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (wr_entry.win_count < cta_pkg::WINDOW_LEN))
        else $error("window count stored at or above window length");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ({1'b0, rem_reg} < divisor))
        else $error("divider remainder not below divisor");

endmodule

[sv/cta_ctrl.sv]
// cta_ctrl: one-hot sequencer for the channel trimmed average smoother
// depends on cta_pkg; issues cta_pkg::cmd_t to cta_datapath and reads cta_pkg::status_t
module cta_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cta_pkg::status_t  status,
    output cta_pkg::cmd_t     cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_CALC  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DSET  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ok_reg;
    logic   ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read = 1'b1;
                // bad channel, or out-of-range sample while averaging, leaves all state alone
                if (!status.in_range || (status.averaging && status.sample_bad))
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (status.averaging && !status.win_full)
                begin
                    ok_next    = 1'b0;
                    state_next = S_WRITE;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = S_DSET;
                end
            end
            S_DSET:
            begin
                if (status.jump)
                    state_next = S_WRITE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write        = 1'b1;
                cmd.write_smooth = ok_reg;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.emit_ok = ok_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded while output register still held");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_last) |=> (state_reg == S_WRITE))
        else $error("divider finished without state write");

endmodule

[sv/channel_trimmed_average_smoother.sv]
// channel_trimmed_average_smoother: top level, config register and controller/datapath hookup
// depends on cta_pkg, cta_ctrl and cta_datapath
//
// Takes one sample item for one of CHANNELS channels and returns exactly one result item.
// With pre-averaging on and counter_range low, each channel collects ten samples, drops the
// largest and smallest and passes sum/8 on every tenth sample; other samples give value 65535
// with valid_res low, as does a sample above 1023 or a channel at or above CHANNELS. The
// value then enters the channel's smoother: a jump of 100 or more moves halfway, otherwise
// (weight*old+new)/(weight+1), truncated. One item is processed at a time. The controller
// steps through read and done when no state changes; read, calc, multiply, write and done
// when the window is not yet full; adds the divider setup state before write on a jump; and
// runs the 16-step restoring divider between setup and write otherwise. Done waits while the
// previous result is held; the output register lets an item be accepted while it waits.
// All channel state reads as zero after reset, and pre-averaging is enabled.
module channel_trimmed_average_smoother #(
    parameter int CHANNELS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [cta_pkg::CH_W-1:0]        channel,
    input  logic [cta_pkg::SAMPLE_W-1:0]    sample,
    input  logic [cta_pkg::WEIGHT_W-1:0]    weight,
    input  logic                            counter_range,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [cta_pkg::SAMPLE_W-1:0]    value,
    output logic                            valid_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data
);

    logic              pre_average_enable_reg;
    cta_pkg::cmd_t     cmd;
    cta_pkg::status_t  status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_average_enable_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            pre_average_enable_reg <= cfg_data;
    end

    cta_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    cta_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .channel            (channel),
        .sample             (sample),
        .weight             (weight),
        .counter_range      (counter_range),
        .pre_average_enable (pre_average_enable_reg),
        .cmd                (cmd),
        .status             (status),
        .result_stall       (result_stall),
        .result_valid       (result_valid),
        .value              (value),
        .valid_res          (valid_res)
    );

endmodule
